// ===== rtl/csm_pkg.sv =====
// ----------------------------------------------------------------------------
// csm_pkg
// Shared types, constants and the case fold for the substring matcher.
// ----------------------------------------------------------------------------
package csm_pkg;

	localparam int unsigned CHAR_W        = 8;
	localparam int unsigned NEEDLE_BYTES_W = 64;
	localparam int unsigned NEEDLE_LEN_W  = 4;
	localparam int unsigned CFG_INDEX_W   = 1;
	localparam int unsigned CFG_DATA_W    = 64;

	localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_BYTES  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_LENGTH = 1'd1;

	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5a;
	localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'd32;

	typedef struct packed {
		logic              valid;
		logic [CHAR_W-1:0] text_lc;
		logic              last;
	} csm_stage_t;

	typedef struct packed {
		logic advance;
		logic found;
	} csm_status_t;

	function automatic logic [CHAR_W-1:0] fold_lower(input logic [CHAR_W-1:0] b);
		logic [CHAR_W-1:0] r;
		r = b;
		if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
			r = b + CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

// ===== rtl/csm_text_if.sv =====
// ----------------------------------------------------------------------------
// csm_text_if
// Text channel: one haystack byte per word with an end-of-text mark.
// ----------------------------------------------------------------------------
interface csm_text_if;
	logic                      valid;
	logic                      ready;
	logic [csm_pkg::CHAR_W-1:0] text_byte;
	logic                      end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ===== rtl/csm_result_if.sv =====
// ----------------------------------------------------------------------------
// csm_result_if
// Result channel: sticky found flag and last mark, one word per text byte.
// ----------------------------------------------------------------------------
interface csm_result_if;
	logic valid;
	logic ready;
	logic found;
	logic is_last;

	modport source (output valid, output found, output is_last, input ready);
	modport sink   (input valid, input found, input is_last, output ready);
endinterface

// ===== rtl/csm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// csm_cfg_regs
// Needle registers and the effective needle length derived from them.
// ----------------------------------------------------------------------------
module csm_cfg_regs #(
	parameter int unsigned MAX_NEEDLE = 8,
	parameter int unsigned LEN_W = $clog2(MAX_NEEDLE + 1)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [csm_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [csm_pkg::CFG_DATA_W-1:0]       cfg_data,
	output logic [csm_pkg::NEEDLE_BYTES_W-1:0]   needle_bytes,
	output logic [LEN_W-1:0]                     needle_len
);

	logic [csm_pkg::NEEDLE_BYTES_W-1:0] needle_bytes_q;
	logic [csm_pkg::NEEDLE_LEN_W-1:0]   needle_length_q;
	logic [LEN_W-1:0]                   lim;
	logic                               zero_seen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_bytes_q  <= '0;
			needle_length_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				csm_pkg::CFG_NEEDLE_BYTES:  needle_bytes_q  <= cfg_data;
				csm_pkg::CFG_NEEDLE_LENGTH: needle_length_q <= cfg_data[csm_pkg::NEEDLE_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp, then cut at the first zero byte
	always_comb begin
		if (32'(needle_length_q) > MAX_NEEDLE) begin
			lim = LEN_W'(MAX_NEEDLE);
		end else begin
			lim = LEN_W'(needle_length_q);
		end
		needle_len = lim;
		zero_seen  = 1'b0;
		for (int k = 0; k < MAX_NEEDLE; k++) begin
			if (!zero_seen && LEN_W'(k) < lim && needle_bytes_q[8*k +: 8] == '0) begin
				needle_len = LEN_W'(k);
				zero_seen  = 1'b1;
			end
		end
	end

	assign needle_bytes = needle_bytes_q;

endmodule

// ===== rtl/csm_input_stage.sv =====
// ----------------------------------------------------------------------------
// csm_input_stage
// Input register: fold the text byte to lower case and hold it for the core.
// ----------------------------------------------------------------------------
module csm_input_stage (
	input  logic                clk,
	input  logic                arst_n,
	csm_text_if.sink            text,
	input  csm_pkg::csm_status_t status,
	output csm_pkg::csm_stage_t  stage_s1
);

	logic                       valid_s1;
	logic [csm_pkg::CHAR_W-1:0] text_lc_s1;
	logic                       last_s1;

	assign text.ready = !valid_s1 || status.advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			text_lc_s1 <= csm_pkg::fold_lower(text.text_byte);
			last_s1    <= text.end_of_text;
		end
	end

	assign stage_s1.valid   = valid_s1;
	assign stage_s1.text_lc = text_lc_s1;
	assign stage_s1.last    = last_s1;

endmodule

// ===== rtl/csm_match_core.sv =====
// ----------------------------------------------------------------------------
// csm_match_core
// Window shift, parallel needle compare, sticky flag and result register.
// ----------------------------------------------------------------------------
module csm_match_core #(
	parameter int unsigned MAX_NEEDLE = 8,
	parameter int unsigned LEN_W = $clog2(MAX_NEEDLE + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  csm_pkg::csm_stage_t                stage_s1,
	input  logic [csm_pkg::NEEDLE_BYTES_W-1:0] needle_bytes,
	input  logic [LEN_W-1:0]                   needle_len,
	csm_result_if.source                       result,
	output csm_pkg::csm_status_t               status
);

	logic [csm_pkg::CHAR_W-1:0] window_q [MAX_NEEDLE];
	logic [csm_pkg::CHAR_W-1:0] win_next [MAX_NEEDLE];
	logic                       found_q;
	logic                       hit;
	logic                       out_valid_q;
	logic                       out_found_q;
	logic                       out_last_q;
	logic                       advance;
	logic                       found_next;

	assign advance = stage_s1.valid && (!out_valid_q || result.ready);

	always_comb begin
		win_next[0] = stage_s1.text_lc;
		for (int i = 1; i < MAX_NEEDLE; i++) begin
			win_next[i] = window_q[i-1];
		end
	end

	// needle byte k sits at window position len-1-k
	always_comb begin
		logic m;
		hit = (needle_len == '0);
		for (int l = 1; l <= MAX_NEEDLE; l++) begin
			m = 1'b1;
			for (int k = 0; k < l; k++) begin
				if (win_next[l-1-k] != needle_bytes[8*k +: 8]) begin
					m = 1'b0;
				end
			end
			if (needle_len == LEN_W'(l)) begin
				hit = m;
			end
		end
	end

	assign found_next = found_q || hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			for (int i = 0; i < MAX_NEEDLE; i++) begin
				window_q[i] <= '0;
			end
		end else if (advance) begin
			found_q <= stage_s1.last ? 1'b0 : found_next;
			for (int i = 0; i < MAX_NEEDLE; i++) begin
				window_q[i] <= stage_s1.last ? '0 : win_next[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || result.ready) begin
			out_valid_q <= stage_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_found_q <= found_next;
			out_last_q  <= stage_s1.last;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.found   = out_found_q;
	assign result.is_last = out_last_q;

	assign status.advance = advance;
	assign status.found   = found_q;

endmodule

// ===== rtl/case_insensitive_substring_match_top.sv =====
// ----------------------------------------------------------------------------
// case_insensitive_substring_match_top
// Streaming case-insensitive substring search over a byte-wide text channel.
// ----------------------------------------------------------------------------
// Usage:
//   text   : valid/ready channel, one haystack byte per word, end_of_text
//            marks the final byte of a string.
//   result : one word per text word, found (sticky within the string) and
//            is_last (copy of end_of_text).
//   cfg_*  : write port; index 0 loads the packed needle bytes, index 1 the
//            needle length. Write only while no text is in flight.
// From text accept to result valid a word passes an input register that
// folds the byte, then the window compare that loads the result register.
// Throughput is one word per cycle while the receiver keeps result.ready
// high. A result waiting on a stalled receiver does not block the
// input register from taking the next word; once both hold words, text.ready
// drops until result.ready returns. Reset clears the needle, the window,
// the found flag and both valid bits. After the last byte of a string the
// window and flag clear for the next string.
// ----------------------------------------------------------------------------
module case_insensitive_substring_match_top #(
	parameter int unsigned MAX_NEEDLE = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	csm_text_if.sink                        text,
	csm_result_if.source                    result,
	input  logic                            cfg_we,
	input  logic [csm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [csm_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int unsigned LEN_W = $clog2(MAX_NEEDLE + 1);

	logic [csm_pkg::NEEDLE_BYTES_W-1:0] needle_bytes;
	logic [LEN_W-1:0]                   needle_len;
	csm_pkg::csm_stage_t                stage_s1;
	csm_pkg::csm_status_t               status;

	csm_cfg_regs #(
		.MAX_NEEDLE (MAX_NEEDLE),
		.LEN_W      (LEN_W)
	) u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.needle_bytes (needle_bytes),
		.needle_len   (needle_len)
	);

	csm_input_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.text     (text),
		.status   (status),
		.stage_s1 (stage_s1)
	);

	csm_match_core #(
		.MAX_NEEDLE (MAX_NEEDLE),
		.LEN_W      (LEN_W)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.stage_s1     (stage_s1),
		.needle_bytes (needle_bytes),
		.needle_len   (needle_len),
		.result       (result),
		.status       (status)
	);

`ifndef SYNTH
	a_accept_loads_s1: assert property (@(posedge clk) disable iff (!arst_n)
		text.valid && text.ready |=> stage_s1.valid)
		else $error("accepted text word not held in input register");

	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		status.advance |=> result.valid)
		else $error("advanced word did not reach result register");

	a_last_clears_flag: assert property (@(posedge clk) disable iff (!arst_n)
		status.advance && stage_s1.last |=> !status.found)
		else $error("found flag not cleared after last byte");
`endif

endmodule

// ===== tb/sv/case_insensitive_substring_match_top_tb.sv =====
// ----------------------------------------------------------------------------
// case_insensitive_substring_match_top_tb
// Self-checking bench for the streaming case-insensitive substring matcher.
// A scoreboard class folds each accepted text word into its own window and
// predicts the sticky found flag, then compares every result word against
// that prediction. It runs a directed set of needles and strings, then
// random needles with strings seeded by needle fragments in random case,
// under sender and receiver idling in three phases, the last with none.
// ----------------------------------------------------------------------------
module case_insensitive_substring_match_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_NEEDLE   = 8;
	localparam int unsigned LATENCY      = 2;
	localparam int unsigned STALL_LIMIT  = 5000;
	localparam int unsigned RANDOM_WORDS = 1850;

	localparam logic [csm_pkg::CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
	localparam logic [csm_pkg::CHAR_W-1:0] CHAR_LOWER_Z = 8'h7a;

	typedef logic [csm_pkg::CHAR_W-1:0] char_t;
	typedef logic [csm_pkg::CFG_DATA_W-1:0] cfg_word_t;
	typedef logic [csm_pkg::NEEDLE_LEN_W-1:0] len_t;
	typedef logic [csm_pkg::CFG_INDEX_W-1:0] cfg_idx_t;

	typedef struct packed {
		logic found;
		logic is_last;
	} verdict_t;

	class match_scoreboard;
		char_t     window [MAX_NEEDLE];
		logic      seen;
		cfg_word_t needle;
		len_t      needle_len;
		verdict_t  verdicts [$];
		int        errors;

		function new();
			foreach (window[i]) window[i] = '0;
			seen       = 1'b0;
			needle     = '0;
			needle_len = '0;
			errors     = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, cfg_word_t data);
			if (idx == csm_pkg::CFG_NEEDLE_BYTES) begin
				needle = data;
			end else if (idx == csm_pkg::CFG_NEEDLE_LENGTH) begin
				needle_len = data[csm_pkg::NEEDLE_LEN_W-1:0];
			end
		endfunction

		function char_t needle_char(int unsigned k);
			return needle[(k % MAX_NEEDLE)*csm_pkg::CHAR_W +: csm_pkg::CHAR_W];
		endfunction

		function int unsigned match_length();
			int unsigned lim;
			int unsigned n;
			lim = (needle_len > MAX_NEEDLE) ? MAX_NEEDLE : needle_len;
			n   = 0;
			while (n < lim && needle_char(n) != '0) n++;
			return n;
		endfunction

		function void note_text(char_t b, logic eot);
			char_t       lc;
			int unsigned len;
			logic        hit;
			verdict_t    v;
			lc  = (b >= csm_pkg::CHAR_UPPER_A && b <= csm_pkg::CHAR_UPPER_Z) ?
				char_t'(b + csm_pkg::CASE_OFFSET) : b;
			len = match_length();
			for (int i = MAX_NEEDLE - 1; i > 0; i--) window[i] = window[i-1];
			window[0] = lc;
			hit = 1'b1;
			for (int unsigned k = 0; k < len; k++) begin
				if (window[len-1-k] != needle_char(k)) hit = 1'b0;
			end
			if (hit) seen = 1'b1;
			v.found   = seen;
			v.is_last = eot;
			verdicts.push_back(v);
			if (eot) begin
				foreach (window[i]) window[i] = '0;
				seen = 1'b0;
			end
		endfunction

		function void check_result(logic found, logic is_last);
			verdict_t v;
			if (verdicts.size() == 0) begin
				$error("result word with no text word pending: found=%0b is_last=%0b",
					found, is_last);
				errors++;
				return;
			end
			v = verdicts.pop_front();
			if (found !== v.found) begin
				$error("found: expected %0b, actual %0b", v.found, found);
				errors++;
			end
			if (is_last !== v.is_last) begin
				$error("is_last: expected %0b, actual %0b", v.is_last, is_last);
				errors++;
			end
		endfunction

		function int pending();
			return verdicts.size();
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n;
	logic      cfg_we;
	cfg_idx_t  cfg_index;
	cfg_word_t cfg_data;

	csm_text_if   text ();
	csm_result_if result ();

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned quiet_cycles  = 0;
	int unsigned words_sent    = 0;
	cfg_word_t   stim_needle   = '0;
	int unsigned stim_len      = 0;

	match_scoreboard sb = new();

	case_insensitive_substring_match_top #(
		.MAX_NEEDLE(MAX_NEEDLE)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.text     (text),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (result.valid === 1'b1 && result.ready === 1'b1) begin
			sb.check_result(result.found, result.is_last);
		end
		result.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (text.valid === 1'b1 && text.ready === 1'b1) ||
				(result.valid === 1'b1 && result.ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic write_needle(input cfg_word_t bytes, input len_t len);
		cfg_we    <= 1'b1;
		cfg_index <= csm_pkg::CFG_NEEDLE_BYTES;
		cfg_data  <= bytes;
		@(posedge clk);
		sb.write_reg(csm_pkg::CFG_NEEDLE_BYTES, bytes);
		cfg_index <= csm_pkg::CFG_NEEDLE_LENGTH;
		cfg_data  <= csm_pkg::CFG_DATA_W'(len);
		@(posedge clk);
		sb.write_reg(csm_pkg::CFG_NEEDLE_LENGTH, csm_pkg::CFG_DATA_W'(len));
		cfg_we      <= 1'b0;
		stim_needle  = bytes;
		stim_len     = len;
	endtask

	task automatic send_word(input char_t b, input logic eot);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			text.valid <= 1'b0;
			@(posedge clk);
		end
		text.valid       <= 1'b1;
		text.text_byte   <= b;
		text.end_of_text <= eot;
		do @(posedge clk); while (text.ready !== 1'b1);
		sb.note_text(b, eot);
		words_sent++;
	endtask

	task automatic send_packed(input logic [63:0] chars, input int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			send_word(chars[i*csm_pkg::CHAR_W +: csm_pkg::CHAR_W], i == n - 1);
	endtask

	task automatic drain();
		text.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	function automatic char_t flip_case(char_t c);
		if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z && $urandom_range(0, 1) == 1)
			return char_t'(c - csm_pkg::CASE_OFFSET);
		return c;
	endfunction

	function automatic char_t random_char();
		int unsigned k;
		char_t       c;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				k = $urandom_range(0, MAX_NEEDLE - 1);
				c = stim_needle[k*csm_pkg::CHAR_W +: csm_pkg::CHAR_W];
				if (k >= stim_len || c == '0) c = CHAR_LOWER_A + char_t'($urandom_range(0, 3));
				return flip_case(c);
			end
			5, 6, 7: return flip_case(CHAR_LOWER_A + char_t'($urandom_range(0, 3)));
			default: return char_t'($urandom_range(1, 255));
		endcase
	endfunction

	task automatic random_needle();
		cfg_word_t   bytes;
		int unsigned len;
		int unsigned r;
		char_t       c;
		bytes = '0;
		case ($urandom_range(0, 9))
			0:       len = 0;
			1:       len = $urandom_range(MAX_NEEDLE + 1, 15);
			default: len = $urandom_range(1, MAX_NEEDLE);
		endcase
		for (int unsigned k = 0; k < MAX_NEEDLE; k++) begin
			r = $urandom_range(0, 19);
			if (r < 14)      c = CHAR_LOWER_A + char_t'($urandom_range(0, 3));
			else if (r < 16) c = csm_pkg::CHAR_UPPER_A + char_t'($urandom_range(0, 3));
			else if (r < 19) c = char_t'($urandom_range(1, 255));
			else             c = '0;
			if (k >= len && $urandom_range(0, 5) != 0) c = '0;
			bytes[k*csm_pkg::CHAR_W +: csm_pkg::CHAR_W] = c;
		end
		write_needle(bytes, len_t'(len));
	endtask

	task automatic send_random_string();
		char_t       s [$];
		int unsigned n;
		char_t       c;
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
		while (s.size() < n) begin
			if ($urandom_range(0, 3) == 0) begin
				for (int unsigned k = 0; k < stim_len && k < MAX_NEEDLE; k++) begin
					c = stim_needle[k*csm_pkg::CHAR_W +: csm_pkg::CHAR_W];
					if (c != '0) s.push_back(flip_case(c));
				end
			end else begin
				s.push_back(random_char());
			end
		end
		foreach (s[i]) send_word(s[i], i == s.size() - 1);
	endtask

	initial begin
		arst_n           = 1'b0;
		text.valid       = 1'b0;
		text.text_byte   = '0;
		text.end_of_text = 1'b0;
		result.ready     = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (LATENCY) @(posedge clk);

		// plain match in mixed case, with top and bottom byte values around it
		write_needle(64'h0000_0000_0063_6261, 4'd3);
		send_packed(64'h0000_0143_4241_ff78, 6);
		drain();
		// empty needle matches on the first byte
		write_needle(64'h0, 4'd0);
		send_packed(64'h80, 1);
		drain();
		// uppercase needle byte never matches
		write_needle(64'h4241, 4'd2);
		send_packed(64'h6261, 2);
		drain();
		// zero byte cuts the needle short
		write_needle(64'h0062_0061, 4'd3);
		send_packed(64'h4151, 2);
		drain();
		// full-width needle with the length saturating
		write_needle(64'h6867_6665_6463_6261, 4'd15);
		send_packed(64'h4847_4645_4443_4241, 8);
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0:       begin send_idle_pct = 20; recv_idle_pct = 59; end
				1:       begin send_idle_pct = 59; recv_idle_pct = 20; end
				default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
			endcase
			while (words_sent < RANDOM_WORDS * (phase + 1) / 3) begin
				random_needle();
				repeat ($urandom_range(2, 8)) send_random_string();
				drain();
			end
		end

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/csm_pkg.sv
rtl/csm_text_if.sv
rtl/csm_result_if.sv
rtl/csm_cfg_regs.sv
rtl/csm_input_stage.sv
rtl/csm_match_core.sv
rtl/case_insensitive_substring_match_top.sv
tb/sv/case_insensitive_substring_match_top_tb.sv
